[src/ffpa_pkg.sv]
// Shared types and constants for the first-fit page allocator.
// No dependencies; ffpa_ctrl and the top level import this package.
package ffpa_pkg;

  localparam int POOL_DEPTH   = 32;
  localparam int LEDGER_DEPTH = 4096;
  localparam int POOL_AW      = $clog2(POOL_DEPTH);
  localparam int CNT_W        = $clog2(POOL_DEPTH + 1);
  localparam int LEDGER_AW    = $clog2(LEDGER_DEPTH);
  localparam int LCNT_W       = LEDGER_AW + 1;

  localparam int ADDR_W     = 48;
  localparam int PAGES_W    = 36;
  localparam int PAGE_SHIFT = 12;
  localparam int SUM_W      = ADDR_W + 2;
  localparam int ROOT_W     = 8;
  localparam int CFG_AW     = 2;

  localparam logic [ROOT_W-1:0] ROOT_RESET   = 8'd43;
  localparam logic [15:0]       USABLE_TYPES = 16'h009E;
  localparam logic [CFG_AW-1:0] CFG_ROOT_ADDR = 2'd0;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_SEAL  = 2'd1,
    OP_ALLOC = 2'd2,
    OP_FREE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_SKIPPED    = 3'd1,
    ST_MISALIGNED = 3'd2,
    ST_NO_SPACE   = 3'd3,
    ST_NOT_FOUND  = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ADD_CHK, S_ADD_RD, S_ADD_CMP,
    S_SEAL_RD, S_SEAL_CMP, S_SEAL_SWEEP, S_SEAL_ROOT,
    S_AL_RD, S_AL_CMP, S_AL_OVL, S_AL_FIT, S_AL_SLOT,
    S_FREE_SCAN, S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [3:0]         region_type;
    logic [ADDR_W-1:0]  byte_address;
    logic [PAGES_W-1:0] page_count;
  } in_word_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ADDR_W-1:0] granted_address;
  } out_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  base;
    logic [PAGES_W-1:0] pages;
  } pool_ent_t;

  typedef struct packed {
    logic               free;
    logic [POOL_AW-1:0] region;
    logic [ADDR_W-1:0]  base;
    logic [PAGES_W-1:0] pages;
  } resv_ent_t;

  typedef struct packed {
    logic               we;
    logic [POOL_AW-1:0] waddr;
    pool_ent_t          wdata;
    logic [POOL_AW-1:0] raddr;
  } pool_req_t;

  typedef struct packed {
    logic                 we;
    logic [LEDGER_AW-1:0] waddr;
    resv_ent_t            wdata;
    logic                 re;
    logic [LEDGER_AW-1:0] raddr;
  } led_req_t;

endpackage

[src/ffpa_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ffpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[src/ffpa_ctrl.sv]
// Sequencer for the allocator: walks the pool and ledger memories per opcode.
// Depends on ffpa_pkg; drives the two RAMs through request structs.
module ffpa_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  ffpa_pkg::in_word_t        in_word,
  input  logic [ffpa_pkg::ROOT_W-1:0] root_pages,
  output logic                      res_valid,
  input  logic                      res_ready,
  output ffpa_pkg::out_word_t       res_word,
  output ffpa_pkg::pool_req_t       pool_req,
  input  ffpa_pkg::pool_ent_t       pool_rdata,
  output ffpa_pkg::led_req_t        led_req,
  input  ffpa_pkg::resv_ent_t       led_rdata
);
  import ffpa_pkg::*;

  state_e               state_r, state_nxt;
  logic [3:0]           type_r, type_nxt;
  logic [ADDR_W-1:0]    base_r, base_nxt;
  logic [PAGES_W-1:0]   pages_r, pages_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]     pos_r, pos_nxt;
  logic [LCNT_W-1:0]    iss_r, iss_nxt;
  logic [2:0]           status_r, status_nxt;
  logic [ADDR_W-1:0]    grant_r, grant_nxt;
  logic [SUM_W-1:0]     start_r, start_nxt;
  logic [SUM_W-1:0]     stl_r, stl_nxt;
  logic [SUM_W-1:0]     limit_r, limit_nxt;
  logic                 d_vld_r;
  logic [LEDGER_AW-1:0] d_idx_r;
  logic                 a_vld_r;
  logic [ADDR_W-1:0]    a_rs_r;
  logic [SUM_W-1:0]     a_re_r;
  logic [SUM_W-1:0]     a_rel_r;

  logic                 usable, base_zero, zero_small, misal, full, add_stop;
  logic [ADDR_W-1:0]    adj_base;
  logic [PAGES_W-1:0]   adj_pages, clip_pages;
  logic [PAGES_W:0]     room;
  logic                 idx_end, pos_zero, scan_end, iss_last;
  logic                 al_small, seal_fit, ovl_hit, slot_found, free_found, no_fit;
  logic [SUM_W-1:0]     len, rd_re;

  // Shared decode of the current word and memory data
  always_comb begin
    usable     = USABLE_TYPES[type_r];
    base_zero  = (base_r == '0);
    zero_small = base_zero && (pages_r <= PAGES_W'(1));
    adj_base   = base_zero ? ADDR_W'(1 << PAGE_SHIFT) : base_r;
    adj_pages  = base_zero ? pages_r - PAGES_W'(1) : pages_r;
    misal      = |adj_base[PAGE_SHIFT-1:0];
    full       = (count_r >= CNT_W'(POOL_DEPTH));
    add_stop   = !usable || zero_small || misal || full;
    room       = (PAGES_W+1)'(1) << PAGES_W;
    room       = room - {1'b0, adj_base[ADDR_W-1:PAGE_SHIFT]};
    clip_pages = ({1'b0, adj_pages} > room) ? room[PAGES_W-1:0] : adj_pages;

    idx_end    = (idx_r >= count_r);
    pos_zero   = (pos_r == '0);
    scan_end   = (iss_r == LCNT_W'(LEDGER_DEPTH));
    iss_last   = (iss_r == LCNT_W'(LEDGER_DEPTH - 1));
    len        = SUM_W'({pages_r, {PAGE_SHIFT{1'b0}}});
    rd_re      = SUM_W'(led_rdata.base) + SUM_W'({led_rdata.pages, {PAGE_SHIFT{1'b0}}});

    al_small   = (pool_rdata.pages < pages_r);
    seal_fit   = (pool_rdata.pages >= PAGES_W'(root_pages));
    ovl_hit    = a_vld_r && (SUM_W'(a_rs_r) < a_re_r) && (start_r < a_re_r)
                 && (SUM_W'(a_rs_r) < stl_r);
    slot_found = d_vld_r && led_rdata.free;
    free_found = d_vld_r && !led_rdata.free && (led_rdata.base == base_r);
    no_fit     = (stl_r > limit_r);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:      if (iss_last) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          case (op_e'(in_word.opcode))
            OP_ADD:   state_nxt = S_ADD_CHK;
            OP_SEAL:  state_nxt = S_SEAL_RD;
            OP_ALLOC: state_nxt = S_AL_RD;
            default:  state_nxt = S_FREE_SCAN;
          endcase
        end
      end
      S_ADD_CHK:    state_nxt = add_stop ? S_DONE : S_ADD_RD;
      S_ADD_RD:     state_nxt = pos_zero ? S_DONE : S_ADD_CMP;
      S_ADD_CMP:    state_nxt = (pool_rdata.pages > pages_r) ? S_ADD_RD : S_DONE;
      S_SEAL_RD:    state_nxt = idx_end ? S_DONE : S_SEAL_CMP;
      S_SEAL_CMP:   state_nxt = seal_fit ? S_SEAL_SWEEP : S_SEAL_RD;
      S_SEAL_SWEEP: if (iss_last) state_nxt = S_SEAL_ROOT;
      S_SEAL_ROOT:  state_nxt = S_DONE;
      S_AL_RD:      state_nxt = (pages_r == '0 || idx_end) ? S_DONE : S_AL_CMP;
      S_AL_CMP:     state_nxt = al_small ? S_AL_RD : S_AL_OVL;
      S_AL_OVL:     if (scan_end && !d_vld_r && !a_vld_r) state_nxt = S_AL_FIT;
      S_AL_FIT:     state_nxt = no_fit ? S_AL_RD : S_AL_SLOT;
      S_AL_SLOT: begin
        if (slot_found) state_nxt = S_DONE;
        else if (scan_end && !d_vld_r) state_nxt = S_AL_RD;
      end
      S_FREE_SCAN: begin
        if (free_found || (scan_end && !d_vld_r)) state_nxt = S_DONE;
      end
      S_DONE:       if (res_ready) state_nxt = S_IDLE;
      default:      state_nxt = S_IDLE;
    endcase
  end

  // Outputs: handshakes and memory requests
  always_comb begin
    in_ready  = (state_r == S_IDLE);
    res_valid = (state_r == S_DONE);
    res_word  = '{status: status_r, granted_address: grant_r};

    pool_req       = '0;
    pool_req.raddr = idx_r[POOL_AW-1:0];
    led_req        = '0;
    led_req.raddr  = iss_r[LEDGER_AW-1:0];

    case (state_r)
      S_CLEAR, S_SEAL_SWEEP: begin
        led_req.we         = 1'b1;
        led_req.waddr      = iss_r[LEDGER_AW-1:0];
        led_req.wdata.free = 1'b1;
      end
      S_SEAL_ROOT: begin
        led_req.we    = 1'b1;
        led_req.wdata = '{free: 1'b0, region: idx_r[POOL_AW-1:0], base: grant_r,
                          pages: PAGES_W'(root_pages)};
      end
      S_ADD_RD: begin
        pool_req.raddr = POOL_AW'(pos_r - CNT_W'(1));
        pool_req.waddr = pos_r[POOL_AW-1:0];
        pool_req.wdata = '{base: base_r, pages: pages_r};
        pool_req.we    = pos_zero;
      end
      S_ADD_CMP: begin
        pool_req.we    = 1'b1;
        pool_req.waddr = pos_r[POOL_AW-1:0];
        pool_req.wdata = (pool_rdata.pages > pages_r) ? pool_rdata
                         : pool_ent_t'{base: base_r, pages: pages_r};
      end
      S_AL_OVL: led_req.re = !scan_end;
      S_AL_SLOT: begin
        led_req.re    = !scan_end;
        led_req.we    = slot_found;
        led_req.waddr = d_idx_r;
        led_req.wdata = '{free: 1'b0, region: idx_r[POOL_AW-1:0],
                          base: start_r[ADDR_W-1:0], pages: pages_r};
      end
      S_FREE_SCAN: begin
        led_req.re         = !scan_end;
        led_req.we         = free_found;
        led_req.waddr      = d_idx_r;
        led_req.wdata      = led_rdata;
        led_req.wdata.free = 1'b1;
      end
      default: ;
    endcase
  end

  // Datapath register updates
  always_comb begin
    type_nxt   = type_r;
    base_nxt   = base_r;
    pages_nxt  = pages_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    iss_nxt    = iss_r;
    status_nxt = status_r;
    grant_nxt  = grant_r;
    start_nxt  = start_r;
    stl_nxt    = stl_r;
    limit_nxt  = limit_r;
    case (state_r)
      S_CLEAR, S_SEAL_SWEEP: iss_nxt = iss_r + LCNT_W'(1);
      S_IDLE: begin
        type_nxt   = in_word.region_type;
        base_nxt   = in_word.byte_address;
        pages_nxt  = in_word.page_count;
        idx_nxt    = '0;
        grant_nxt  = '0;
        iss_nxt    = (op_e'(in_word.opcode) == OP_FREE) ? LCNT_W'(1) : '0;
        status_nxt = ST_OK;
      end
      S_ADD_CHK: begin
        if (!usable || zero_small) status_nxt = ST_SKIPPED;
        else if (misal) status_nxt = ST_MISALIGNED;
        else if (full) status_nxt = ST_SKIPPED;
        base_nxt  = adj_base;
        pages_nxt = clip_pages;
        pos_nxt   = count_r;
      end
      S_ADD_RD: if (pos_zero) count_nxt = count_r + CNT_W'(1);
      S_ADD_CMP: begin
        if (pool_rdata.pages > pages_r) pos_nxt = pos_r - CNT_W'(1);
        else count_nxt = count_r + CNT_W'(1);
      end
      S_SEAL_RD: if (idx_end) status_nxt = ST_NO_SPACE;
      S_SEAL_CMP: begin
        if (seal_fit) begin
          grant_nxt = pool_rdata.base;
          iss_nxt   = LCNT_W'(1);
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      S_AL_RD: if (pages_r == '0 || idx_end) status_nxt = ST_NO_SPACE;
      S_AL_CMP: begin
        if (al_small) begin
          idx_nxt = idx_r + CNT_W'(1);
        end else begin
          start_nxt = SUM_W'(pool_rdata.base);
          stl_nxt   = SUM_W'(pool_rdata.base) + len;
          limit_nxt = SUM_W'(pool_rdata.base)
                      + SUM_W'({pool_rdata.pages, {PAGE_SHIFT{1'b0}}});
          iss_nxt   = '0;
        end
      end
      S_AL_OVL: begin
        if (!scan_end) iss_nxt = iss_r + LCNT_W'(1);
        if (ovl_hit) begin
          start_nxt = a_re_r;
          stl_nxt   = a_rel_r;
        end
      end
      S_AL_FIT: begin
        if (no_fit) idx_nxt = idx_r + CNT_W'(1);
        else iss_nxt = '0;
      end
      S_AL_SLOT: begin
        if (!scan_end) iss_nxt = iss_r + LCNT_W'(1);
        if (slot_found) grant_nxt = start_r[ADDR_W-1:0];
        else if (scan_end && !d_vld_r) idx_nxt = idx_r + CNT_W'(1);
      end
      S_FREE_SCAN: begin
        if (!scan_end) iss_nxt = iss_r + LCNT_W'(1);
        if (!free_found && scan_end && !d_vld_r) status_nxt = ST_NOT_FOUND;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      count_r <= '0;
      iss_r   <= '0;
      d_vld_r <= 1'b0;
      a_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      iss_r   <= iss_nxt;
      d_vld_r <= led_req.re;
      a_vld_r <= d_vld_r && (state_r == S_AL_OVL) && !led_rdata.free
                 && (led_rdata.region == idx_r[POOL_AW-1:0]);
    end
  end

  // Payload registers and overlap stage
  always_ff @(posedge clk) begin
    type_r   <= type_nxt;
    base_r   <= base_nxt;
    pages_r  <= pages_nxt;
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    status_r <= status_nxt;
    grant_r  <= grant_nxt;
    start_r  <= start_nxt;
    stl_r    <= stl_nxt;
    limit_r  <= limit_nxt;
    d_idx_r  <= led_req.raddr;
    a_rs_r   <= led_rdata.base;
    a_re_r   <= rd_re;
    a_rel_r  <= rd_re + len;
  end

endmodule

[src/first_fit_page_allocator_unit.sv]
// First-fit page allocator top level: config port, RAMs, sequencer, output word register.
// Depends on ffpa_pkg, ffpa_ram and ffpa_ctrl.
// Add: shifts pool entries up one at a time to insert the new region. Seal: checks regions
// in turn, then sweeps the ledger. Alloc: per fitting region, an overlap pass and then a
// free-slot pass over the ledger. Free: scans the ledger for the matching base.
// The ledger RAM has a single read port; one word is in flight at a time.
// After reset a clearing pass marks every ledger entry free before in_ready.
module first_fit_page_allocator_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  ffpa_pkg::in_word_t        in_word,
  output logic                      out_valid,
  input  logic                      out_ready,
  output ffpa_pkg::out_word_t       out_word,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [ffpa_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]               cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready
);
  import ffpa_pkg::*;

  logic [ROOT_W-1:0] root_r;
  logic              out_valid_r;
  out_word_t         out_word_r;
  logic              res_valid, res_ready;
  out_word_t         res_word;
  pool_req_t         pool_req;
  pool_ent_t         pool_rdata;
  led_req_t          led_req;
  resv_ent_t         led_rdata;

  // Config register: single register, written on the access cycle
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == CFG_ROOT_ADDR) ? 32'(root_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= ROOT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      root_r <= cfg_pwdata[ROOT_W-1:0];
    end
  end

  // Output word register
  assign res_ready = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_word_r <= res_word;
    end
  end

  // Region pool memory
  ffpa_ram #(.WIDTH($bits(pool_ent_t)), .DEPTH(POOL_DEPTH)) u_pool (
    .clk   (clk),
    .we    (pool_req.we),
    .waddr (pool_req.waddr),
    .wdata (pool_req.wdata),
    .raddr (pool_req.raddr),
    .rdata (pool_rdata)
  );

  // Reservation ledger memory
  ffpa_ram #(.WIDTH($bits(resv_ent_t)), .DEPTH(LEDGER_DEPTH)) u_ledger (
    .clk   (clk),
    .we    (led_req.we),
    .waddr (led_req.waddr),
    .wdata (led_req.wdata),
    .raddr (led_req.raddr),
    .rdata (led_rdata)
  );

  // Opcode sequencer
  ffpa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .root_pages (root_r),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_word   (res_word),
    .pool_req   (pool_req),
    .pool_rdata (pool_rdata),
    .led_req    (led_req),
    .led_rdata  (led_rdata)
  );

endmodule
